FILE: hw/rtl/hysteresis_level_quantizer_defines.svh
// Assertion helpers for the level quantizer.
// Each macro expands to one labeled concurrent assertion on clk.
`ifndef HYSTERESIS_LEVEL_QUANTIZER_DEFINES_SVH
`define HYSTERESIS_LEVEL_QUANTIZER_DEFINES_SVH

// Checked only while out of reset.
`define HLQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define HLQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/hlq_pkg.sv
`timescale 1ns / 1ps

package hlq_pkg;

    // Field widths
    localparam int SAMPLE_W    = 10;
    localparam int EP_BITS     = 10;
    localparam int EXT_W       = EP_BITS + 1;
    localparam int MARGIN_BITS = 8;
    localparam int LEVEL_BITS  = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 10;

    // Endpoint table: up to six levels, seven boundaries
    localparam int MAX_LEVELS = 6;
    localparam int NUM_EP     = MAX_LEVELS + 1;

    // Reset values
    localparam logic [MARGIN_BITS-1:0] MARGIN_RST = 8'd10;
    localparam logic [EP_BITS-1:0]     EP0_RST    = 10'd0;
    localparam logic [EP_BITS-1:0]     EP1_RST    = 10'd550;
    localparam logic [EP_BITS-1:0]     EP_TOP_RST = 10'd1023;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MARGIN = 3'd0,
        REG_EP0    = 3'd1,
        REG_EP1    = 3'd2,
        REG_EP2    = 3'd3,
        REG_EP3    = 3'd4,
        REG_EP4    = 3'd5,
        REG_EP5    = 3'd6,
        REG_EP6    = 3'd7
    } cfg_idx_t;

    // Configuration seen by the decision logic
    typedef struct packed {
        logic [MARGIN_BITS-1:0]           margin;
        logic [NUM_EP-1:0][EP_BITS-1:0]   ep;
    } cfg_t;

endpackage

FILE: hw/rtl/hlq_sample_if.sv
`timescale 1ns / 1ps

interface hlq_sample_if import hlq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

FILE: hw/rtl/hlq_level_if.sv
`timescale 1ns / 1ps

interface hlq_level_if import hlq_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [LEVEL_BITS-1:0] level;

    modport source (output valid, output level, input ready);
    modport sink   (input valid, input level, output ready);
endinterface

FILE: hw/rtl/hlq_cfg_if.sv
`timescale 1ns / 1ps

interface hlq_cfg_if import hlq_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/hlq_cfg_regs.sv
`timescale 1ns / 1ps

module hlq_cfg_regs import hlq_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    hlq_cfg_if.sink    cfg,
    output cfg_t       cfg_out
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Config writes are always accepted
    assign cfg.ready = 1'b1;

    // Register file write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg_idx_t'(cfg.index))
                REG_MARGIN: cfg_next.margin = cfg.data[MARGIN_BITS-1:0];
                REG_EP0:    cfg_next.ep[0]  = cfg.data[EP_BITS-1:0];
                REG_EP1:    cfg_next.ep[1]  = cfg.data[EP_BITS-1:0];
                REG_EP2:    cfg_next.ep[2]  = cfg.data[EP_BITS-1:0];
                REG_EP3:    cfg_next.ep[3]  = cfg.data[EP_BITS-1:0];
                REG_EP4:    cfg_next.ep[4]  = cfg.data[EP_BITS-1:0];
                REG_EP5:    cfg_next.ep[5]  = cfg.data[EP_BITS-1:0];
                REG_EP6:    cfg_next.ep[6]  = cfg.data[EP_BITS-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.margin <= MARGIN_RST;
            cfg_reg.ep[0]  <= EP0_RST;
            cfg_reg.ep[1]  <= EP1_RST;
            for (int i = 2; i < NUM_EP; i++)
            begin
                cfg_reg.ep[i] <= EP_TOP_RST;
            end
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_out = cfg_reg;

endmodule

FILE: hw/rtl/hlq_level_logic.sv
`timescale 1ns / 1ps

module hlq_level_logic import hlq_pkg::*; #(
    parameter int LEVELS = 2,
    parameter int SW     = 10
) (
    input  cfg_t                  cfg_in,
    input  logic [SW-1:0]         sample,
    input  logic [LEVEL_BITS-1:0] cur_level,
    output logic [LEVEL_BITS-1:0] next_level
);

    localparam logic [LEVEL_BITS-1:0] TOP_LEVEL = LEVEL_BITS'(LEVELS - 1);

    logic [EXT_W-1:0]          s_ext;
    logic [MAX_LEVELS-1:0]     in_band;
    logic [MAX_LEVELS-1:0]     in_range;
    logic [LEVEL_BITS-1:0]     lvl_clamped;
    logic [LEVEL_BITS-1:0]     scan_level;

    assign s_ext = EXT_W'(sample);

    // Per-level widened band and plain range checks
    always_comb
    begin
        logic [EXT_W-1:0] diff;
        logic [EXT_W-1:0] lb;
        logic [EXT_W-1:0] ub;
        logic [EXT_W-1:0] ep_lo;
        logic [EXT_W-1:0] ep_hi;
        in_band  = '0;
        in_range = '0;
        for (int i = 0; i < MAX_LEVELS; i++)
        begin
            ep_lo = EXT_W'(cfg_in.ep[i]);
            ep_hi = EXT_W'(cfg_in.ep[i+1]);
            diff  = ep_lo - EXT_W'(cfg_in.margin);
            // lower edge saturates at zero; level 0 is not widened below
            if (i == 0)
                lb = ep_lo;
            else if (diff[EXT_W-1])
                lb = '0;
            else
                lb = diff;
            ub = ep_hi + EXT_W'(cfg_in.margin);
            if (i < LEVELS)
            begin
                in_band[i]  = (s_ext >= lb) && (s_ext <= ub);
                in_range[i] = (s_ext >= ep_lo) && (s_ext <= ep_hi);
            end
        end
    end

    // Held level clamped to the top level as a guard
    assign lvl_clamped = (cur_level > TOP_LEVEL) ? TOP_LEVEL : cur_level;

    // Lowest matching range wins; no match lands on the top level
    always_comb
    begin
        scan_level = TOP_LEVEL;
        for (int i = MAX_LEVELS - 1; i >= 0; i--)
        begin
            if (in_range[i])
                scan_level = LEVEL_BITS'(i);
        end
    end

    assign next_level = in_band[lvl_clamped] ? lvl_clamped : scan_level;

endmodule

FILE: hw/rtl/hysteresis_level_quantizer.sv
`timescale 1ns / 1ps
// Multi-level hysteresis quantizer.
// Channels: in_ch carries one converter sample per item, out_ch returns one
// quantized level per item, cfg writes the margin (index 0) and the
// endpoints 0..6 (indexes 1..7); cfg is always ready and takes effect on
// the next item.
// Each sample is held in the sample register, then its level in the level
// register, which drives out_ch until the result is taken.
// Throughput: one item per cycle while out_ch takes each result; the level compare
// against the active endpoints is a single pass between those two registers, and
// the held level is the result register itself.
// Reset: the margin returns to 10, endpoints to 0, 550, 1023..., the held
// level to 0, and both stages empty.
// Stall: while out_ch is held off, the finished level waits in the result
// register and one more sample is taken into the input register; in_ch
// then drops ready until the result is taken.
// Parameters: LEVELS (2..6) sets how many endpoint ranges take part;
// SAMPLE_BITS (8..16) masks the incoming sample.

`include "hysteresis_level_quantizer_defines.svh"

module hysteresis_level_quantizer import hlq_pkg::*; #(
    parameter int LEVELS      = 2,
    parameter int SAMPLE_BITS = 10
) (
    input  logic          clk,
    input  logic          rst_n,
    hlq_cfg_if.sink       cfg,
    hlq_sample_if.sink    in_ch,
    hlq_level_if.source   out_ch
);

    localparam int SW = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam logic [LEVEL_BITS-1:0] TOP_LEVEL = LEVEL_BITS'(LEVELS - 1);

    cfg_t                  cfg_cur;
    logic                  in_valid_reg;
    logic [SW-1:0]         sample_reg;
    logic                  out_valid_reg;
    logic [LEVEL_BITS-1:0] level_reg;
    logic [LEVEL_BITS-1:0] level_next;
    logic                  out_free;
    logic                  advance;
    logic                  in_ready;

    hlq_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_cur)
    );

    hlq_level_logic #(
        .LEVELS (LEVELS),
        .SW     (SW)
    ) u_level_logic (
        .cfg_in     (cfg_cur),
        .sample     (sample_reg),
        .cur_level  (level_reg),
        .next_level (level_next)
    );

    // Stage handshake
    assign out_free = !out_valid_reg || out_ch.ready;
    assign advance  = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || advance;

    assign in_ch.ready  = in_ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.level = level_reg;

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_ch.valid)
            sample_reg <= in_ch.sample[SW-1:0];
    end

    // Result stage; level_reg is also the held level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            level_reg     <= '0;
        end
        else
        begin
            if (out_free)
                out_valid_reg <= in_valid_reg;
            if (advance)
                level_reg <= level_next;
        end
    end

    `HLQ_ASSERT_ALWAYS(a_cfg_ready, cfg.ready, "config port not ready")
    `HLQ_ASSERT(a_level_in_range, level_reg <= TOP_LEVEL, "held level above top level")
    `HLQ_ASSERT(a_advance_fills_out, advance |=> out_valid_reg, "item lost between stages")
    `HLQ_ASSERT(a_level_holds, !advance |=> $stable(level_reg), "level changed without an item")
    `HLQ_ASSERT(a_ready_when_empty, !out_valid_reg |-> in_ready, "input blocked with empty output")

endmodule

FILE: tb/hysteresis_level_quantizer_checker.sv
`timescale 1ns / 1ps

// Watches the three channels of the level quantizer, keeps its own copy of
// the margin, the endpoints and the held level, and checks every result
// item against the level predicted for the oldest sample still waiting.
module hysteresis_level_quantizer_checker import hlq_pkg::*; #(
    parameter int LEVELS      = 2,
    parameter int SAMPLE_BITS = 10
) (
    input  logic   clk,
    input  logic   rst_n,
    hlq_cfg_if     cfg,
    hlq_sample_if  in_ch,
    hlq_level_if   out_ch,
    output int     mismatches,
    output int     waiting
);

    logic [MARGIN_BITS-1:0] margin_q;
    logic [EP_BITS-1:0]     ep_q [NUM_EP];
    logic [LEVEL_BITS-1:0]  held_level;
    logic [LEVEL_BITS-1:0]  level_fifo [$];

    // Level that the given sample leads to from the held level
    function automatic logic [LEVEL_BITS-1:0] next_level(input logic [SAMPLE_W-1:0] raw);
        logic [SAMPLE_W-1:0]   s;
        logic [LEVEL_BITS-1:0] lvl;
        logic [EXT_W-1:0]      lo_edge;
        logic [EXT_W-1:0]      hi_edge;
        s   = raw & SAMPLE_W'((1 << SAMPLE_BITS) - 1);
        lvl = held_level;
        if (lvl >= LEVELS)
            lvl = LEVEL_BITS'(LEVELS - 1);

        // widened band of the held level; level 0 keeps its lower edge
        lo_edge = EXT_W'(ep_q[lvl]);
        if (lvl > 0)
            lo_edge = (lo_edge > EXT_W'(margin_q)) ? lo_edge - EXT_W'(margin_q) : '0;
        hi_edge = EXT_W'(ep_q[lvl + 1]) + EXT_W'(margin_q);

        // outside the band: first matching range wins, else top level
        if (s < lo_edge || s > hi_edge)
        begin
            lvl = LEVEL_BITS'(LEVELS - 1);
            for (int i = LEVELS - 1; i >= 0; i--)
            begin
                if (s >= ep_q[i] && s <= ep_q[i + 1])
                    lvl = LEVEL_BITS'(i);
            end
        end
        return lvl;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_q   = MARGIN_RST;
            ep_q[0]    = EP0_RST;
            ep_q[1]    = EP1_RST;
            for (int i = 2; i < NUM_EP; i++)
                ep_q[i] = EP_TOP_RST;
            held_level = '0;
            level_fifo.delete();
            mismatches = 0;
            waiting    = 0;
        end
        else
        begin
            // register writes
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_MARGIN)
                    margin_q = cfg.data[MARGIN_BITS-1:0];
                else
                    ep_q[int'(cfg.index) - 1] = cfg.data[EP_BITS-1:0];
            end

            // result items against the oldest expectation
            if (out_ch.valid && out_ch.ready)
            begin
                if (level_fifo.size() == 0)
                begin
                    $error("level: result item with nothing expected, actual %0d",
                           out_ch.level);
                    mismatches++;
                end
                else if (out_ch.level !== level_fifo[0])
                begin
                    $error("level mismatch: expected %0d, actual %0d",
                           level_fifo[0], out_ch.level);
                    mismatches++;
                    void'(level_fifo.pop_front());
                end
                else
                    void'(level_fifo.pop_front());
            end

            // sample items update the held level
            if (in_ch.valid && in_ch.ready)
            begin
                held_level = next_level(in_ch.sample);
                level_fifo.push_back(held_level);
            end

            waiting = level_fifo.size();
        end
    end

endmodule

FILE: tb/hysteresis_level_quantizer_tb.sv
`timescale 1ns / 1ps

module hysteresis_level_quantizer_tb;
    import hlq_pkg::*;

    localparam int LEVELS      = 2;
    localparam int SAMPLE_BITS = 10;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 215;
    localparam int STALL_LEN   = 120;

    logic clk = 1'b0;
    logic rst_n;

    int send_idle_pct;
    int recv_idle_pct;
    int stall_reqs;
    int stall_seen;
    int hold_left;
    int mismatches;
    int waiting;

    // shadow of the decision config, used only to aim samples at edges
    logic [MARGIN_BITS-1:0] cur_margin;
    logic [EP_BITS-1:0]     cur_ep [3];

    hlq_cfg_if    cfg_bus ();
    hlq_sample_if sample_bus ();
    hlq_level_if  level_bus ();

    hysteresis_level_quantizer #(
        .LEVELS      (LEVELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .in_ch  (sample_bus),
        .out_ch (level_bus)
    );

    hysteresis_level_quantizer_checker #(
        .LEVELS      (LEVELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) level_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_bus),
        .in_ch      (sample_bus),
        .out_ch     (level_bus),
        .mismatches (mismatches),
        .waiting    (waiting)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Run limit
    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side: random ready, plus long hold-offs on request
    initial
    begin
        level_bus.ready = 1'b0;
        hold_left       = 0;
        stall_seen      = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_reqs != stall_seen)
            begin
                stall_seen = stall_reqs;
                hold_left  = STALL_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                level_bus.ready = 1'b0;
            end
            else
                level_bus.ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_reg(input cfg_idx_t idx, input int d);
        @(negedge clk);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data  = CFG_DATA_W'(d);
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
    endtask

    // Writes every register; only called while nothing is in flight
    task automatic write_all(input int m, input int e [7]);
        write_reg(REG_MARGIN, m);
        write_reg(REG_EP0, e[0]);
        write_reg(REG_EP1, e[1]);
        write_reg(REG_EP2, e[2]);
        write_reg(REG_EP3, e[3]);
        write_reg(REG_EP4, e[4]);
        write_reg(REG_EP5, e[5]);
        write_reg(REG_EP6, e[6]);
        @(negedge clk);
        cfg_bus.valid = 1'b0;
        cur_margin = MARGIN_BITS'(m);
        for (int i = 0; i < 3; i++)
            cur_ep[i] = EP_BITS'(e[i]);
    endtask

    // Random config: reset-like, ascending, arbitrary or extreme endpoints
    task automatic pick_config(input int kind);
        int m;
        int e [7];
        m = $urandom_range(255);
        for (int i = 0; i < 7; i++)
            e[i] = $urandom_range(1023);
        case (kind)
            0:
            begin
                e[0] = EP0_RST;
                e[1] = EP1_RST;
                e[2] = EP_TOP_RST;
            end
            1:
            begin
                e[0] = $urandom_range(300);
                e[1] = e[0] + $urandom_range(500);
                e[2] = e[1] + $urandom_range(1023 - e[1]);
            end
            3:
            begin
                m = $urandom_range(1) ? 255 : 0;
                for (int i = 0; i < 3; i++)
                    e[i] = $urandom_range(1) ? 1023 : 0;
            end
            default: ;
        endcase
        write_all(m, e);
    endtask

    task automatic send_sample(input int s);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_bus.valid = 1'b0;
            @(negedge clk);
        end
        sample_bus.valid  = 1'b1;
        sample_bus.sample = SAMPLE_W'(s);
        @(posedge clk);
        while (!sample_bus.ready)
            @(posedge clk);
    endtask

    task automatic end_burst();
        @(negedge clk);
        sample_bus.valid = 1'b0;
    endtask

    // Wait until every expected level has come, plus pipeline slack
    task automatic drain();
        while (waiting != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Half near the band edges, some uniform, some at the range ends
    function automatic int pick_sample();
        int k;
        int base;
        int v;
        int m;
        m    = int'(cur_margin);
        k    = $urandom_range(9);
        base = int'(cur_ep[$urandom_range(2)]);
        if (k < 4)
            v = $urandom_range(1023);
        else if (k < 8)
            v = base + int'($urandom_range(2 * m + 8)) - (m + 4);
        else if (k == 8)
            v = $urandom_range(1) ? 1023 : 0;
        else if ($urandom_range(1))
            v = base + m + int'($urandom_range(2)) - 1;
        else
            v = base - m + int'($urandom_range(2)) - 1;
        if (v < 0)
            v = 0;
        if (v > 1023)
            v = 1023;
        return v;
    endfunction

    initial
    begin
        rst_n             = 1'b0;
        sample_bus.valid  = 1'b0;
        sample_bus.sample = '0;
        cfg_bus.valid     = 1'b0;
        cfg_bus.index     = REG_MARGIN;
        cfg_bus.data      = '0;
        send_idle_pct     = 33;
        recv_idle_pct     = 78;
        stall_reqs        = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset values, crossing the margin both ways
        write_all(10, '{0, 550, 1023, 1023, 1023, 1023, 1023});
        send_sample(0);
        send_sample(560);
        send_sample(561);
        send_sample(1023);
        send_sample(540);
        send_sample(539);
        send_sample(550);
        send_sample(0);
        end_burst();
        drain();

        // Max margin: below every range, lower edge saturating, upper edge past 1023
        write_all(255, '{100, 200, 1023, 512, 0, 1023, 341});
        send_sample(50);
        send_sample(0);
        send_sample(1023);
        send_sample(150);
        end_burst();
        drain();

        // Zero margin, unordered endpoints: second range is empty
        write_all(0, '{0, 900, 300, 682, 1, 1022, 0});
        send_sample(950);
        send_sample(100);
        send_sample(900);
        send_sample(901);
        send_sample(300);
        end_burst();
        drain();

        // Endpoints 0 to 2 at the top
        write_all(128, '{1023, 1023, 1023, 0, 0, 0, 0});
        send_sample(1023);
        send_sample(0);
        send_sample(512);
        send_sample(1023);
        send_sample(0);
        end_burst();

        // Random phases under three idle patterns
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            send_idle_pct = (ph < 2) ? 33 : ((ph < 4) ? 78 : 0);
            recv_idle_pct = (ph < 2) ? 78 : ((ph < 4) ? 33 : 0);
            pick_config(ph % 4);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == 100)
                    stall_reqs++;
                send_sample(pick_sample());
            end
            end_burst();
        end

        drain();
        repeat (10) @(negedge clk);
        if (mismatches == 0 && waiting == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
